/* rtl/core/rwc_pkg.sv */
// Shared types, the Q1.15 quarter-wave sine table and its rescaling function
// for the runway wind components core. No dependencies.
package rwc_pkg;

   typedef struct packed {
      logic [8:0] runway_course;
      logic [8:0] begin_wind_direction;
      logic [7:0] begin_wind_speed;
      logic [8:0] far_wind_direction;
      logic [7:0] far_wind_speed;
   } req_type;

   typedef struct packed {
      logic [7:0] begin_along_speed;
      logic       begin_is_tail;
      logic [7:0] begin_side_speed;
      logic       begin_side_present;
      logic [7:0] far_along_speed;
      logic       far_is_tail;
      logic [7:0] far_side_speed;
      logic       far_side_present;
   } rsp_type;

   typedef struct packed {
      logic [6:0] sine_index;
      logic [6:0] cosine_index;
      logic       along_negative;
   } angle_type;

   localparam int TABLE_FRAC = 15;
   localparam int TABLE_LAST = 90;
   localparam int SCALED_W   = 25;

   localparam logic [15:0] SINE_Q15 [0:90] = '{
          16'd0,   16'd572,  16'd1144,  16'd1715,  16'd2286,
       16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
       16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
       16'd8481,  16'd9032,  16'd9580, 16'd10126, 16'd10668,
      16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
      16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
      16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
      16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
      16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
      16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
      16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
      16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
      16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
      16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
      16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
      16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
      16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
      16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
      16'd32768
   };

   // Table entry rescaled to frac fraction bits, rounded half up when narrowing.
   function automatic logic [SCALED_W-1:0] sine_scaled(input logic [6:0] index,
                                                       input int frac);
      logic [31:0] value;
      logic [6:0]  safe;
      safe = (index > 7'(TABLE_LAST)) ? 7'(TABLE_LAST) : index;
      value = 32'(SINE_Q15[safe]);
      if (frac >= TABLE_FRAC) begin
         value = value << (frac - TABLE_FRAC);
      end else begin
         value = (value + (32'd1 << (TABLE_FRAC - 1 - frac))) >> (TABLE_FRAC - frac);
      end
      return value[SCALED_W-1:0];
   endfunction

endpackage

/* rtl/core/rwc_cell.sv */
// One pipeline cell: a valid bit and a payload register with stall flow control.
// No package dependencies.
module rwc_cell #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;

   assign in_stall  = valid_ff & out_stall;
   assign valid_in  = in_stall ? valid_ff : in_valid;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall && in_valid) begin
         data_ff <= in_data;
      end
   end

endmodule

/* rtl/core/rwc_angle.sv */
// Angle reduction and quadrant folding for one runway end.
// Depends on rwc_pkg for angle_type.
module rwc_angle (
   input  logic                 opposite,
   input  logic [8:0]           course_raw,
   input  logic [8:0]           direction_raw,
   output rwc_pkg::angle_type   angle
);

   localparam logic [8:0] FULL_TURN    = 9'd360;
   localparam logic [8:0] HALF_TURN    = 9'd180;
   localparam logic [8:0] QUARTER_TURN = 9'd90;
   localparam logic [8:0] THREE_QUARTER = 9'd270;

   function automatic logic [6:0] fold(input logic [8:0] a);
      logic [8:0] r;
      if (a <= QUARTER_TURN) begin
         r = a;
      end else if (a <= HALF_TURN) begin
         r = HALF_TURN - a;
      end else if (a <= THREE_QUARTER) begin
         r = a - HALF_TURN;
      end else begin
         r = FULL_TURN - a;
      end
      return r[6:0];
   endfunction

   logic [8:0] course;
   logic [8:0] direction;
   logic [9:0] diff;
   logic [8:0] base;
   logic [8:0] sine_angle;
   logic [8:0] cosine_angle;

   always_comb begin
      course    = (course_raw >= FULL_TURN) ? course_raw - FULL_TURN : course_raw;
      direction = (direction_raw >= FULL_TURN) ? direction_raw - FULL_TURN : direction_raw;
      diff      = {1'b0, direction} - {1'b0, course};
      base      = diff[9] ? 9'(diff + {1'b0, FULL_TURN}) : diff[8:0];
      if (opposite) begin
         sine_angle = (base >= HALF_TURN) ? base - HALF_TURN : base + HALF_TURN;
      end else begin
         sine_angle = base;
      end
      cosine_angle = (sine_angle >= THREE_QUARTER) ? sine_angle - THREE_QUARTER
                                                   : sine_angle + QUARTER_TURN;
      angle.sine_index     = fold(sine_angle);
      angle.cosine_index   = fold(cosine_angle);
      angle.along_negative = cosine_angle > HALF_TURN;
   end

endmodule

/* rtl/core/runway_wind_components_core.sv */
// Top level of the runway wind components core: a row of four pipeline cells.
// Depends on rwc_pkg, rwc_cell and rwc_angle.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/stall    | rwc_pkg::req_type
//   rsp     | out       | rsp_valid/stall    | rwc_pkg::rsp_type
//
// One request enters per cycle unless req_stall is high; each result passes through all four cells in turn.
// The four cells are angle folding, table lookup, multiplication and clipping.
// Reset empties every cell; the core keeps no other state.
// A stalled result holds only the full cells behind it, up to the first empty one.
module runway_wind_components_core #(
   parameter int SINE_FRAC_BITS = 15,
   parameter int SPEED_BITS     = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rwc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rwc_pkg::rsp_type rsp_data
);

   localparam int SPD_W  = (SPEED_BITS < 8) ? SPEED_BITS : 8;
   localparam int MAG_W  = SINE_FRAC_BITS + 1;
   localparam int PROD_W = SPD_W + MAG_W;

   typedef struct packed {
      rwc_pkg::angle_type begin_angle;
      rwc_pkg::angle_type far_angle;
      logic [SPD_W-1:0]   begin_speed;
      logic [SPD_W-1:0]   far_speed;
   } fold_type;

   typedef struct packed {
      logic [MAG_W-1:0] begin_cos;
      logic [MAG_W-1:0] begin_sin;
      logic             begin_negative;
      logic [MAG_W-1:0] far_cos;
      logic [MAG_W-1:0] far_sin;
      logic             far_negative;
      logic [SPD_W-1:0] begin_speed;
      logic [SPD_W-1:0] far_speed;
   } lookup_type;

   typedef struct packed {
      logic [PROD_W-1:0] begin_along;
      logic [PROD_W-1:0] begin_side;
      logic              begin_negative;
      logic [PROD_W-1:0] far_along;
      logic [PROD_W-1:0] far_side;
      logic              far_negative;
   } product_type;

   function automatic logic [7:0] clip(input logic [PROD_W-1:0] product);
      logic [15:0] q;
      q = 16'(product >> SINE_FRAC_BITS);
      return (q > 16'd255) ? 8'hFF : q[7:0];
   endfunction

   function automatic logic [PROD_W-1:0] mul(input logic [SPD_W-1:0] speed,
                                             input logic [MAG_W-1:0] mag);
      return {{MAG_W{1'b0}}, speed} * {{SPD_W{1'b0}}, mag};
   endfunction

   fold_type         fold_d;
   fold_type         fold_q;
   lookup_type       lookup_d;
   lookup_type       lookup_q;
   product_type      product_d;
   product_type      product_q;
   rwc_pkg::rsp_type result_d;

   logic fold_valid;
   logic fold_stall;
   logic lookup_valid;
   logic lookup_stall;
   logic product_valid;
   logic product_stall;

   rwc_angle u_begin_angle (
      .opposite      (1'b1),
      .course_raw    (req_data.runway_course),
      .direction_raw (req_data.begin_wind_direction),
      .angle         (fold_d.begin_angle)
   );

   rwc_angle u_far_angle (
      .opposite      (1'b0),
      .course_raw    (req_data.runway_course),
      .direction_raw (req_data.far_wind_direction),
      .angle         (fold_d.far_angle)
   );

   assign fold_d.begin_speed = req_data.begin_wind_speed[SPD_W-1:0];
   assign fold_d.far_speed   = req_data.far_wind_speed[SPD_W-1:0];

   always_comb begin
      lookup_d.begin_cos = MAG_W'(rwc_pkg::sine_scaled(fold_q.begin_angle.cosine_index,
                                                       SINE_FRAC_BITS));
      lookup_d.begin_sin = MAG_W'(rwc_pkg::sine_scaled(fold_q.begin_angle.sine_index,
                                                       SINE_FRAC_BITS));
      lookup_d.far_cos   = MAG_W'(rwc_pkg::sine_scaled(fold_q.far_angle.cosine_index,
                                                       SINE_FRAC_BITS));
      lookup_d.far_sin   = MAG_W'(rwc_pkg::sine_scaled(fold_q.far_angle.sine_index,
                                                       SINE_FRAC_BITS));
      lookup_d.begin_negative = fold_q.begin_angle.along_negative;
      lookup_d.far_negative   = fold_q.far_angle.along_negative;
      lookup_d.begin_speed    = fold_q.begin_speed;
      lookup_d.far_speed      = fold_q.far_speed;
   end

   always_comb begin
      product_d.begin_along    = mul(lookup_q.begin_speed, lookup_q.begin_cos);
      product_d.begin_side     = mul(lookup_q.begin_speed, lookup_q.begin_sin);
      product_d.begin_negative = lookup_q.begin_negative;
      product_d.far_along      = mul(lookup_q.far_speed, lookup_q.far_cos);
      product_d.far_side       = mul(lookup_q.far_speed, lookup_q.far_sin);
      product_d.far_negative   = lookup_q.far_negative;
   end

   always_comb begin
      result_d.begin_along_speed  = clip(product_q.begin_along);
      result_d.begin_is_tail      = !product_q.begin_negative;
      result_d.begin_side_speed   = clip(product_q.begin_side);
      result_d.begin_side_present = product_q.begin_side != '0;
      result_d.far_along_speed    = clip(product_q.far_along);
      result_d.far_is_tail        = !product_q.far_negative;
      result_d.far_side_speed     = clip(product_q.far_side);
      result_d.far_side_present   = product_q.far_side != '0;
   end

   rwc_cell #(.WIDTH($bits(fold_type))) u_fold_cell (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (fold_d),
      .out_valid (fold_valid),
      .out_stall (fold_stall),
      .out_data  (fold_q)
   );

   rwc_cell #(.WIDTH($bits(lookup_type))) u_lookup_cell (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fold_valid),
      .in_stall  (fold_stall),
      .in_data   (lookup_d),
      .out_valid (lookup_valid),
      .out_stall (lookup_stall),
      .out_data  (lookup_q)
   );

   rwc_cell #(.WIDTH($bits(product_type))) u_product_cell (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lookup_valid),
      .in_stall  (lookup_stall),
      .in_data   (product_d),
      .out_valid (product_valid),
      .out_stall (product_stall),
      .out_data  (product_q)
   );

   rwc_cell #(.WIDTH($bits(rwc_pkg::rsp_type))) u_result_cell (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (product_valid),
      .in_stall  (product_stall),
      .in_data   (result_d),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   // The input side can only be held back by a stall at the output.
   assert property (@(posedge clock) disable iff (reset) !rsp_stall |-> !req_stall)
      else $error("request stalled while the result side is free");

   // An absent side component always reports zero speed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.begin_side_present || rsp_data.begin_side_speed == 8'd0) &&
                    (rsp_data.far_side_present || rsp_data.far_side_speed == 8'd0))
      else $error("side speed reported without a side component");

   // Reset leaves no result pending.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule
